>>> rtl/tagged_field_section_parser_core_macros.svh
// Assertion macros for the tagged-field parser
`ifndef TAGGED_FIELD_SECTION_PARSER_CORE_MACROS_SVH
`define TAGGED_FIELD_SECTION_PARSER_CORE_MACROS_SVH
`ifndef SYNTH
`define TFSP_ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("tfsp: implication failed");
`define TFSP_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("tfsp: next-cycle check failed");
`else
`define TFSP_ASSERT_IMPL(label, clk, rst_n, a, c)
`define TFSP_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

>>> rtl/tfsp_pkg.sv
package tfsp_pkg;
  localparam int unsigned MaxSeenTagsDefault = 16;
  localparam int unsigned MaxVarintBytes     = 5;
  localparam logic [30:0] BudgetReset   = 31'd1048576;
  localparam logic [17:0] TagLimitReset = 18'd131072;

  localparam logic [0:0] CfgBudget   = 1'b0;
  localparam logic [0:0] CfgTagLimit = 1'b1;

  localparam logic [1:0] KindPay   = 2'd0;
  localparam logic [1:0] KindEmpty = 2'd1;
  localparam logic [1:0] KindDone  = 2'd2;
  localparam logic [1:0] KindErr   = 2'd3;

  localparam logic [2:0] ErrNone     = 3'd0;
  localparam logic [2:0] ErrBudget   = 3'd1;
  localparam logic [2:0] ErrSize     = 3'd2;
  localparam logic [2:0] ErrShort    = 3'd3;
  localparam logic [2:0] ErrDup      = 3'd4;
  localparam logic [2:0] ErrVarint   = 3'd5;
  localparam logic [2:0] ErrTblFull  = 3'd6;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] tag_id;
    logic [7:0]  payload_byte;
    logic        tag_end;
    logic [31:0] bytes_consumed;
    logic [2:0]  error_code;
    logic        last_of_run;
  } out_item_t;

  // search request / reply between sequencer and seen-id table
  typedef struct packed {
    logic        start;
    logic        clear;
    logic [31:0] id;
  } srch_req_t;

  typedef struct packed {
    logic done;
    logic dup;
    logic full;
  } srch_rsp_t;
endpackage

>>> rtl/tfsp_seen_table.sv
module tfsp_seen_table #(
  parameter int unsigned MAX_SEEN_TAGS = tfsp_pkg::MaxSeenTagsDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tfsp_pkg::srch_req_t req,
  output tfsp_pkg::srch_rsp_t rsp
);
  import tfsp_pkg::*;

  localparam int unsigned IW = (MAX_SEEN_TAGS > 1) ? $clog2(MAX_SEEN_TAGS) : 1;
  localparam int unsigned CW = $clog2(MAX_SEEN_TAGS + 1);

  logic [31:0] mem [MAX_SEEN_TAGS];
  logic [31:0] rd_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  st_r, st_nxt;
  logic        wr;
  srch_rsp_t   rsp_nxt, rsp_r;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;

  // entries are read one at a time, each compared the cycle after it is read
  always_ff @(posedge clk) begin
    if (st_r == S_RD && idx_r < cnt_r) begin
      rd_r <= mem[idx_r[IW-1:0]];
    end
    if (wr) begin
      mem[cnt_r[IW-1:0]] <= key_r;
    end
  end

  always_comb begin
    st_nxt  = st_r;
    idx_nxt = idx_r;
    cnt_nxt = cnt_r;
    key_nxt = key_r;
    rsp_nxt = '0;
    wr      = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (req.clear) begin
          cnt_nxt = '0;
        end
        if (req.start) begin
          key_nxt = req.id;
          idx_nxt = '0;
          st_nxt  = S_RD;
        end
      end
      S_RD: begin
        if (idx_r < cnt_r) begin
          st_nxt = S_CMP;
        end else if (cnt_r >= CW'(MAX_SEEN_TAGS)) begin
          rsp_nxt = '{done: 1'b1, dup: 1'b0, full: 1'b1};
          st_nxt  = S_IDLE;
        end else begin
          wr      = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          rsp_nxt = '{done: 1'b1, dup: 1'b0, full: 1'b0};
          st_nxt  = S_IDLE;
        end
      end
      S_CMP: begin
        if (rd_r == key_r) begin
          rsp_nxt = '{done: 1'b1, dup: 1'b1, full: 1'b0};
          st_nxt  = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
          st_nxt  = S_RD;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      cnt_r <= '0;
      rsp_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      rsp_r <= rsp_nxt;
    end
    idx_r <= idx_nxt;
    key_r <= key_nxt;
  end

  assign rsp = rsp_r;
endmodule

>>> rtl/tagged_field_section_parser_core.sv
// A stream byte is registered, then executed by the sequencer; a byte that ends a
// tag adds a seen-id search that reads and compares each stored id in turn.
// A new byte is taken only after the last one is through, as set by the single
// sequencer and the blocking output register.
// Up to two results per byte leave through a one-entry output register.
// Reset: synchronous, active low; restores register defaults and idle state.
module tagged_field_section_parser_core #(
  parameter int unsigned MAX_SEEN_TAGS = tfsp_pkg::MaxSeenTagsDefault
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tfsp_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tfsp_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  logic [30:0]          cfg_wdata
);
  import tfsp_pkg::*;
  `include "tagged_field_section_parser_core_macros.svh"

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_ID   = 3'd1;
  localparam logic [2:0] PH_LEN  = 3'd2;
  localparam logic [2:0] PH_PAY  = 3'd3;
  localparam logic [2:0] PH_HALT = 3'd4;

  // sequencer states
  localparam logic [2:0] Q_IDLE = 3'd0;
  localparam logic [2:0] Q_EXEC = 3'd1;
  localparam logic [2:0] Q_OUT1 = 3'd2;
  localparam logic [2:0] Q_SRCH = 3'd3;
  localparam logic [2:0] Q_OUT2 = 3'd4;

  logic [30:0] budget_r;
  logic [17:0] limit_r;
  logic [2:0]  ph_r, ph_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [2:0]  vcnt_r, vcnt_nxt;
  logic [31:0] tags_r, tags_nxt;
  logic [31:0] cid_r, cid_nxt;
  logic [17:0] prem_r, prem_nxt;
  logic [31:0] tot_r, tot_nxt;
  logic [2:0]  sq_r, sq_nxt;
  in_item_t    item_r;
  out_item_t   o1_r, o1_nxt;
  out_item_t   ob_r, ob_nxt;
  logic        ov_r, ov_nxt;
  logic        srch_pend_r, srch_pend_nxt;
  srch_req_t   req;
  srch_rsp_t   rsp;

  tfsp_seen_table #(.MAX_SEEN_TAGS(MAX_SEEN_TAGS)) u_tbl (
    .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= BudgetReset;
      limit_r  <= TagLimitReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgBudget:   budget_r <= cfg_wdata;
        CfgTagLimit: limit_r  <= cfg_wdata[17:0];
        default: ;
      endcase
    end
  end

  assign in_ready = (sq_r == Q_IDLE) && !ov_r;

  // varint decode, budget room and checks
  logic        vd_more, vd_done, vd_long;
  logic [31:0] vd_val, tot_inc, room, part;
  logic        newsec;

  always_comb begin
    newsec  = (ph_r == PH_IDLE) && (vcnt_r == 3'd0);
    tot_inc = newsec ? 32'd1 : ((tot_r == 32'hFFFF_FFFF) ? tot_r : tot_r + 32'd1);
    part    = '0;
    case (vcnt_r)
      3'd0: part = {25'd0, item_r.data_byte[6:0]};
      3'd1: part = {18'd0, item_r.data_byte[6:0], 7'd0};
      3'd2: part = {11'd0, item_r.data_byte[6:0], 14'd0};
      3'd3: part = {4'd0, item_r.data_byte[6:0], 21'd0};
      3'd4: part = {item_r.data_byte[3:0], 28'd0};
      default: part = '0;
    endcase
    vd_val  = acc_r | part;
    vd_long = (vcnt_r >= 3'(MaxVarintBytes)) ||
              (item_r.data_byte[7] && (vcnt_r + 3'd1 >= 3'(MaxVarintBytes)));
    vd_done = !vd_long && !item_r.data_byte[7];
    vd_more = !vd_long && item_r.data_byte[7];
    room    = ({1'b0, budget_r} > tot_inc) ? ({1'b0, budget_r} - tot_inc) : 32'd0;
  end

  function automatic out_item_t mk(logic [1:0] k, logic [31:0] id, logic [7:0] pb,
                                   logic te, logic [31:0] tot, logic [2:0] ec);
    out_item_t o;
    o.kind = k; o.tag_id = id; o.payload_byte = pb; o.tag_end = te;
    o.bytes_consumed = tot; o.error_code = ec; o.last_of_run = 1'b1;
    return o;
  endfunction

  always_comb begin
    ph_nxt = ph_r; acc_nxt = acc_r; vcnt_nxt = vcnt_r; tags_nxt = tags_r;
    cid_nxt = cid_r; prem_nxt = prem_r; tot_nxt = tot_r; sq_nxt = sq_r;
    o1_nxt = o1_r; ob_nxt = ob_r; ov_nxt = ov_r; srch_pend_nxt = srch_pend_r;
    req = '0;
    if (out_valid && out_ready) begin
      ov_nxt = 1'b0;
    end
    unique case (sq_r)
      Q_IDLE: begin
        if (in_valid && in_ready) begin
          sq_nxt = Q_EXEC;
        end
      end
      Q_EXEC: begin
        sq_nxt = Q_IDLE;
        srch_pend_nxt = 1'b0;
        if (item_r.command) begin
          if (ph_r == PH_HALT) begin
            ph_nxt = PH_IDLE;
          end else if (!newsec) begin
            o1_nxt = mk(KindErr, cid_r, 8'd0, 1'b0, tot_r, ErrShort);
            ph_nxt = PH_HALT; acc_nxt = '0; vcnt_nxt = '0;
            sq_nxt = Q_OUT1;
          end
        end else if (ph_r != PH_HALT) begin
          tot_nxt = tot_inc;
          if (newsec) begin
            cid_nxt = '0;
            req.clear = 1'b1;
          end
          if (ph_r == PH_PAY) begin
            prem_nxt = prem_r - 18'd1;
            o1_nxt = mk(KindPay, cid_r, item_r.data_byte, prem_nxt == '0, tot_inc, ErrNone);
            srch_pend_nxt = (prem_nxt == '0);
            o1_nxt.last_of_run = !srch_pend_nxt;
            sq_nxt = Q_OUT1;
          end else if (vd_long) begin
            o1_nxt = mk(KindErr, newsec ? 32'd0 : cid_r, 8'd0, 1'b0, tot_inc, ErrVarint);
            ph_nxt = PH_HALT; acc_nxt = '0; vcnt_nxt = '0;
            sq_nxt = Q_OUT1;
          end else if (vd_more) begin
            acc_nxt = vd_val; vcnt_nxt = vcnt_r + 3'd1;
          end else begin
            acc_nxt = '0; vcnt_nxt = '0;
            if (ph_r == PH_IDLE) begin
              if (vd_val == '0) begin
                o1_nxt = mk(KindDone, 32'd0, 8'd0, 1'b0, tot_inc, ErrNone);
                sq_nxt = Q_OUT1;
              end else begin
                tags_nxt = vd_val; ph_nxt = PH_ID;
              end
            end else if (ph_r == PH_ID) begin
              cid_nxt = vd_val; ph_nxt = PH_LEN;
            end else if (vd_val > room) begin
              o1_nxt = mk(KindErr, cid_r, 8'd0, 1'b0, tot_inc, ErrBudget);
              ph_nxt = PH_HALT; sq_nxt = Q_OUT1;
            end else if (vd_val > {14'd0, limit_r}) begin
              o1_nxt = mk(KindErr, cid_r, 8'd0, 1'b0, tot_inc, ErrSize);
              ph_nxt = PH_HALT; sq_nxt = Q_OUT1;
            end else if (vd_val == '0) begin
              o1_nxt = mk(KindEmpty, cid_r, 8'd0, 1'b1, tot_inc, ErrNone);
              o1_nxt.last_of_run = 1'b0;
              srch_pend_nxt = 1'b1;
              sq_nxt = Q_OUT1;
            end else begin
              prem_nxt = vd_val[17:0]; ph_nxt = PH_PAY;
            end
          end
        end
      end
      Q_OUT1: begin
        if (!ov_nxt) begin
          ob_nxt = o1_r; ov_nxt = 1'b1;
          if (srch_pend_r) begin
            req.start = 1'b1; req.id = cid_r;
            sq_nxt = Q_SRCH;
          end else begin
            sq_nxt = Q_IDLE;
          end
        end
      end
      Q_SRCH: begin
        if (rsp.done) begin
          srch_pend_nxt = 1'b0;
          if (rsp.dup || rsp.full) begin
            o1_nxt = mk(KindErr, cid_r, 8'd0, 1'b0, tot_r, rsp.dup ? ErrDup : ErrTblFull);
            ph_nxt = PH_HALT;
            sq_nxt = Q_OUT2;
          end else begin
            tags_nxt = tags_r - 32'd1;
            if (tags_r == 32'd1) begin
              o1_nxt = mk(KindDone, 32'd0, 8'd0, 1'b0, tot_r, ErrNone);
              ph_nxt = PH_IDLE;
              sq_nxt = Q_OUT2;
            end else begin
              ph_nxt = PH_ID;
              o1_nxt = ob_r;
              ob_nxt.last_of_run = 1'b1;
              sq_nxt = Q_OUT2;
            end
          end
        end
      end
      Q_OUT2: begin
        // a tag end with no second result re-emits nothing: flag in o1 kind
        if (!ov_nxt) begin
          if (!(o1_r.kind == KindPay || o1_r.kind == KindEmpty)) begin
            ob_nxt = o1_r; ov_nxt = 1'b1;
          end
          sq_nxt = Q_IDLE;
        end
      end
      default: sq_nxt = Q_IDLE;
    endcase
  end

  // Tag end: the first result sits in the output register with its last flag
  // low until the seen-id search tells whether a second result follows.
  logic hold_last;
  assign hold_last = (sq_r == Q_SRCH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r <= Q_IDLE; ph_r <= PH_IDLE; vcnt_r <= '0; acc_r <= '0;
      tags_r <= '0; cid_r <= '0; prem_r <= '0; tot_r <= '0;
      ov_r <= 1'b0; srch_pend_r <= 1'b0;
    end else begin
      sq_r <= sq_nxt; ph_r <= ph_nxt; vcnt_r <= vcnt_nxt; acc_r <= acc_nxt;
      tags_r <= tags_nxt; cid_r <= cid_nxt; prem_r <= prem_nxt; tot_r <= tot_nxt;
      ov_r <= ov_nxt; srch_pend_r <= srch_pend_nxt;
    end
    o1_r <= o1_nxt;
    ob_r <= ob_nxt;
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  // the first result of a tag end is held back until its last flag is known
  assign out_valid = ov_r && !hold_last;
  assign out_data  = ob_r;

  `TFSP_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, sq_r != Q_IDLE, !in_ready)
  `TFSP_ASSERT_IMPL(a_err_code, clk, rst_n, out_valid && out_data.kind != KindErr,
                    out_data.error_code == ErrNone)
  `TFSP_ASSERT_NEXT(a_accept_exec, clk, rst_n, in_valid && in_ready, sq_r == Q_EXEC)
endmodule
